// File: sv/hse_pkg.sv
// Package with types, constants and helper functions for the HMAC-SHA-1 engine.
package hse_pkg;

	localparam int KeyWords = 8;
	localparam int KeyIdxW = 3;
	localparam int BufDepth = 16;

	localparam logic [31:0] IpadWord = 32'h36363636;
	localparam logic [31:0] OpadWord = 32'h5c5c5c5c;
	localparam logic [31:0] OuterLen = 32'd672;

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	typedef logic [31:0] word_t;
	typedef word_t [4:0] hash_t;

	localparam hash_t ShaIv = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
		32'hefcdab89, 32'h67452301};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_IPAD_LOAD,
		ST_BYTE,
		ST_PAD,
		ST_SAVE_INNER,
		ST_OPAD_LOAD,
		ST_OUTER_LOAD,
		ST_COMPRESS,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		RET_BYTE,
		RET_PAD,
		RET_INNER,
		RET_OPAD,
		RET_OUTER
	} ret_t;

	function automatic word_t rotl(input word_t v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

endpackage

// File: sv/hse_round.sv
// Iterative SHA-1 compression unit: one round per cycle over a 16-word schedule window.
module hse_round (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  hse_pkg::hash_t chain_in,
	input  hse_pkg::word_t blk [16],
	output hse_pkg::hash_t chain_out,
	output logic           done
);
	import hse_pkg::*;

	word_t w_q [16];
	word_t a_q, b_q, c_q, d_q, e_q;
	hash_t h_q;
	logic [6:0] t_q;
	logic run_q, done_q;
	word_t wt, f, k, tmp;

	always_comb begin
		if (t_q < 7'd16) begin
			wt = w_q[t_q[3:0]];
		end else begin
			wt = rotl(w_q[4'(t_q[3:0] + 4'd13)] ^ w_q[4'(t_q[3:0] + 4'd8)]
				^ w_q[4'(t_q[3:0] + 4'd2)] ^ w_q[t_q[3:0]], 1);
		end
		if (t_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (t_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (t_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		tmp = rotl(a_q, 5) + f + e_q + k + wt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			t_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				t_q <= '0;
			end else if (run_q) begin
				if (t_q == 7'd79) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
				t_q <= t_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w_q <= blk;
			h_q <= chain_in;
			a_q <= chain_in[0];
			b_q <= chain_in[1];
			c_q <= chain_in[2];
			d_q <= chain_in[3];
			e_q <= chain_in[4];
		end else if (run_q) begin
			w_q[t_q[3:0]] <= wt;
			a_q <= tmp;
			b_q <= a_q;
			c_q <= rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign chain_out[0] = h_q[0] + a_q;
	assign chain_out[1] = h_q[1] + b_q;
	assign chain_out[2] = h_q[2] + c_q;
	assign chain_out[3] = h_q[3] + d_q;
	assign chain_out[4] = h_q[4] + e_q;
	assign done = done_q;

endmodule

// File: sv/hmac_sha1_engine.sv
// Top level of the HMAC-SHA-1 engine: key registers, byte packer, padding and sequencer.
// Usage: write the key into registers 0 to 7 through the cfg channel while idle.
// Stream message words on the input channel; each transaction carries up to four
// leading bytes and a last mark. The first word of a message first runs the
// 80-round compression over key xor 0x36. The byte packer then takes the bytes
// of each word in turn and closes the word; in_ready stays low until then, so a
// new word is taken only once the last one is done. Every 64th byte starts a
// block compression. A last word is closed and followed by padding (9 to 72 pad
// bytes), one or two inner compressions, saving of the inner digest and two
// outer compressions.
// Five result transactions then follow, index 0 to 4, the last marked, one per
// cycle while the receiver is ready.
// The sequencer runs every compression on the shared round unit; in_ready
// is low whenever the block is working on a word or emitting results.
// A stalled receiver holds the current result; nothing else advances.
// Reset clears the key, the counters and the sequencer; the block then idles.
module hmac_sha1_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] message_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_result
);
	import hse_pkg::*;

	logic [63:0] key_q [KeyWords];
	hash_t chain_q, inner_q, comp_out;
	word_t buf_q [BufDepth];
	word_t blk [BufDepth];
	logic [63:0] bits_q, len_q;
	word_t part_q, word_q;
	logic [1:0] fill_q;
	logic [2:0] nb_q, bi_q;
	logic last_q, started_q, pad_first_q;
	logic [3:0] lenb_q;
	logic [2:0] oidx_q;
	state_t state_q, state_d;
	ret_t ret_q;
	logic comp_start, comp_done;
	logic [7:0] cur_byte;
	logic byte_go;
	logic [5:0] pos;

	assign pos = bits_q[8:3];
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign digest_word = chain_q[oidx_q];
	assign word_index = oidx_q;
	assign last_result = (oidx_q == 3'd4);

	// The last buffer word is taken straight from the packer, since it is
	// completed at the same edge that starts the block compression.
	always_comb begin
		for (int i = 0; i < BufDepth; i++) begin
			if (state_q == ST_IPAD_LOAD) begin
				blk[i] = (i[0] ? key_q[i >> 1][31:0] : key_q[i >> 1][63:32]) ^ IpadWord;
			end else if (state_q == ST_OPAD_LOAD) begin
				blk[i] = (i[0] ? key_q[i >> 1][31:0] : key_q[i >> 1][63:32]) ^ OpadWord;
			end else if (state_q == ST_OUTER_LOAD) begin
				blk[i] = (i < 5) ? inner_q[i] : (i == 5) ? 32'h80000000 :
					(i == 15) ? OuterLen : 32'h0;
			end else if (i == BufDepth - 1) begin
				blk[i] = part_q | word_t'(cur_byte);
			end else begin
				blk[i] = buf_q[i];
			end
		end
	end

	always_comb begin
		cur_byte = 8'h00;
		byte_go = 1'b0;
		if (state_q == ST_BYTE) begin
			byte_go = (bi_q < nb_q);
			case (bi_q[1:0])
				2'd0: cur_byte = word_q[31:24];
				2'd1: cur_byte = word_q[23:16];
				2'd2: cur_byte = word_q[15:8];
				default: cur_byte = word_q[7:0];
			endcase
		end else if (state_q == ST_PAD) begin
			byte_go = 1'b1;
			if (pad_first_q) begin
				cur_byte = 8'h80;
			end else if (lenb_q != 4'd0) begin
				cur_byte = len_q[63:56];
			end
		end
	end

	hse_round u_round (
		.clk(clk), .arst_n(arst_n), .start(comp_start), .chain_in(chain_q), .blk(blk),
		.chain_out(comp_out), .done(comp_done)
	);

	assign comp_start = (state_q == ST_IPAD_LOAD) || (state_q == ST_OPAD_LOAD)
		|| (state_q == ST_OUTER_LOAD) || (byte_go && pos == 6'd63);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = started_q ? ST_BYTE : ST_IPAD_LOAD;
			ST_IPAD_LOAD, ST_OPAD_LOAD, ST_OUTER_LOAD: state_d = ST_COMPRESS;
			ST_BYTE: begin
				if (byte_go) begin
					if (pos == 6'd63) state_d = ST_COMPRESS;
				end else begin
					state_d = last_q ? ST_PAD : ST_IDLE;
				end
			end
			ST_PAD: if (pos == 6'd63) state_d = ST_COMPRESS;
			ST_COMPRESS: if (comp_done) begin
				unique case (ret_q)
					RET_PAD: state_d = ST_PAD;
					RET_INNER: state_d = ST_SAVE_INNER;
					RET_OPAD: state_d = ST_OUTER_LOAD;
					RET_OUTER: state_d = ST_EMIT;
					default: state_d = ST_BYTE;
				endcase
			end
			ST_SAVE_INNER: state_d = ST_OPAD_LOAD;
			ST_EMIT: if (out_ready && oidx_q == 3'd4) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KeyWords; i++) key_q[i] <= '0;
			chain_q <= ShaIv;
			bits_q <= '0;
			part_q <= '0;
			fill_q <= '0;
			started_q <= 1'b0;
			oidx_q <= '0;
			bi_q <= '0;
			nb_q <= '0;
			last_q <= 1'b0;
			lenb_q <= '0;
			pad_first_q <= 1'b0;
			ret_q <= RET_BYTE;
			word_q <= '0;
			len_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) key_q[cfg_index] <= cfg_data;
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					word_q <= message_word;
					nb_q <= (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
					last_q <= last_word;
					bi_q <= '0;
					if (!started_q) begin
						chain_q <= ShaIv;
						bits_q <= 64'd512;
						part_q <= '0;
						fill_q <= '0;
						started_q <= 1'b1;
					end
				end
				ST_IPAD_LOAD: ret_q <= RET_BYTE;
				ST_BYTE, ST_PAD: begin
					if (byte_go) begin
						if (fill_q == 2'd3) begin
							part_q <= '0;
						end else begin
							part_q <= part_q | (word_t'(cur_byte) << (5'd24 - {fill_q, 3'b000}));
						end
						fill_q <= fill_q + 2'd1;
						bits_q <= bits_q + 64'd8;
						if (state_q == ST_BYTE) begin
							bi_q <= bi_q + 3'd1;
							ret_q <= RET_BYTE;
						end else begin
							pad_first_q <= 1'b0;
							if (!pad_first_q && lenb_q != 4'd0) begin
								lenb_q <= lenb_q - 4'd1;
								len_q <= {len_q[55:0], 8'h00};
							end else if (pos == 6'd55) begin
								lenb_q <= 4'd8;
							end
							ret_q <= (lenb_q == 4'd1) ? RET_INNER : RET_PAD;
						end
					end else if (last_q) begin
						pad_first_q <= 1'b1;
						len_q <= bits_q;
						lenb_q <= '0;
					end
				end
				ST_COMPRESS: if (comp_done) chain_q <= comp_out;
				ST_SAVE_INNER: chain_q <= ShaIv;
				ST_OPAD_LOAD: ret_q <= RET_OPAD;
				ST_OUTER_LOAD: ret_q <= RET_OUTER;
				ST_EMIT: if (out_ready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd4) begin
						oidx_q <= '0;
						chain_q <= ShaIv;
						bits_q <= '0;
						part_q <= '0;
						fill_q <= '0;
						started_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (byte_go && fill_q == 2'd3) begin
			buf_q[pos[5:2]] <= part_q | word_t'(cur_byte);
		end
		if (state_q == ST_SAVE_INNER) begin
			inner_q <= chain_q;
		end
	end

endmodule

// File: tb/sv/hmac_sha1_engine_tb.sv
// Testbench for the HMAC-SHA-1 engine: directed and random message streams checked against a software HMAC.
`timescale 1ns / 1ps

class hmac_scoreboard;
	logic [63:0] key [8];
	logic [31:0] chain [5];
	logic [31:0] blk [16];
	logic [63:0] bit_cnt;
	logic [31:0] part_word;
	int part_fill;
	bit in_msg;
	logic [31:0] pending_digest [$];
	int errors;

	function new();
		foreach (key[i]) key[i] = '0;
		foreach (blk[i]) blk[i] = '0;
		in_msg = 0;
		errors = 0;
		bit_cnt = '0;
		part_word = '0;
		part_fill = 0;
	endfunction

	function logic [31:0] rl(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function void sha_block(ref logic [31:0] h [5], input logic [31:0] b [16]);
		logic [31:0] w [16];
		logic [31:0] a, bb, c, d, e, f, k, wt, t;
		w = b;
		a = h[0]; bb = h[1]; c = h[2]; d = h[3]; e = h[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 16) wt = w[r];
			else begin
				wt = rl(w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15], 1);
				w[r & 15] = wt;
			end
			if (r < 20) begin
				f = (bb & c) | (~bb & d); k = hse_pkg::K0;
			end else if (r < 40) begin
				f = bb ^ c ^ d; k = hse_pkg::K1;
			end else if (r < 60) begin
				f = (bb & c) | (bb & d) | (c & d); k = hse_pkg::K2;
			end else begin
				f = bb ^ c ^ d; k = hse_pkg::K3;
			end
			t = rl(a, 5) + f + e + k + wt;
			e = d; d = c; c = rl(bb, 30); bb = a; a = t;
		end
		h[0] += a; h[1] += bb; h[2] += c; h[3] += d; h[4] += e;
	endfunction

	function void key_pad_hash(logic [31:0] pad);
		logic [31:0] kb [16];
		for (int i = 0; i < 5; i++) chain[i] = hse_pkg::ShaIv[i];
		for (int i = 0; i < 16; i++)
			kb[i] = ((i & 1) ? key[i >> 1][31:0] : key[i >> 1][63:32]) ^ pad;
		sha_block(chain, kb);
	endfunction

	function void push_byte(logic [7:0] by);
		int pos;
		pos = bit_cnt[8:3];
		part_word |= 32'(by) << (24 - 8 * part_fill);
		if (part_fill == 3) begin
			blk[pos >> 2] = part_word;
			part_word = '0;
			part_fill = 0;
		end else part_fill++;
		bit_cnt += 8;
		if (pos == 63) sha_block(chain, blk);
	endfunction

	function void note_word(logic [31:0] wd, logic [2:0] nb, logic lst);
		int n;
		logic [63:0] len;
		logic [31:0] inner [5];
		logic [31:0] ob [16];
		n = (nb > 4) ? 4 : nb;
		if (!in_msg) begin
			key_pad_hash(hse_pkg::IpadWord);
			bit_cnt = 64'd512;
			part_word = '0;
			part_fill = 0;
			in_msg = 1;
		end
		for (int i = 0; i < n; i++) push_byte(wd[31 - 8 * i -: 8]);
		if (!lst) return;
		len = bit_cnt;
		push_byte(8'h80);
		while (bit_cnt[8:3] != 56) push_byte(8'h00);
		for (int i = 0; i < 8; i++) push_byte(len[63 - 8 * i -: 8]);
		inner = chain;
		key_pad_hash(hse_pkg::OpadWord);
		foreach (ob[i]) ob[i] = '0;
		for (int i = 0; i < 5; i++) ob[i] = inner[i];
		ob[5] = 32'h80000000;
		ob[15] = hse_pkg::OuterLen;
		sha_block(chain, ob);
		for (int i = 0; i < 5; i++) pending_digest.push_back(chain[i]);
		in_msg = 0;
		bit_cnt = '0;
		part_word = '0;
		part_fill = 0;
	endfunction

	function void report(string what);
		$display("mismatch: %s", what);
		errors++;
	endfunction

	function void check_digest(logic [31:0] dw, logic [2:0] idx, logic lst);
		logic [31:0] want;
		int pos;
		if (pending_digest.size() == 0) begin
			report($sformatf("unexpected digest word %h", dw));
			return;
		end
		pos = (5 - pending_digest.size() % 5) % 5;
		want = pending_digest.pop_front();
		if (dw !== want) report($sformatf("digest_word %h, want %h", dw, want));
		if (idx !== 3'(pos)) report($sformatf("word_index %0d, want %0d", idx, pos));
		if (lst !== (pos == 4)) report($sformatf("last_result %b at index %0d", lst, pos));
	endfunction
endclass

module hmac_sha1_engine_tb;
	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 0, in_ready;
	logic [31:0] message_word = '0;
	logic [2:0] valid_bytes = '0;
	logic last_word = 0;
	logic out_valid, out_ready = 0;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_result;

	hmac_scoreboard hmac_sb = new();
	int idle_cycles = 0;
	bit hold_long = 0;
	bit stim_done = 0;

	hmac_sha1_engine dut (.*);

	always #10 clk = ~clk;

	task automatic write_key(int idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= 3'(idx);
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		hmac_sb.key[idx] = val;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send_word(logic [31:0] wd, logic [2:0] nb, logic lst, bit gap);
		if (gap && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
		@(negedge clk);
		in_valid <= 1;
		message_word <= wd;
		valid_bytes <= nb;
		last_word <= lst;
		do @(posedge clk); while (!in_ready);
		hmac_sb.note_word(wd, nb, lst);
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic send_message(int words, bit gap);
		for (int i = 0; i < words; i++) begin
			logic [2:0] nb;
			nb = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
			send_word($urandom, nb, i == words - 1, gap);
		end
	endtask

	task automatic drain();
		while (hmac_sb.pending_digest.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_key(int mode);
		for (int i = 0; i < 8; i++)
			case (mode)
				0: write_key(i, '0);
				1: write_key(i, '1);
				default: write_key(i, (i < $urandom_range(0, 8)) ? {$urandom, $urandom} : 64'd0);
			endcase
	endtask

	always @(negedge clk) begin
		if (hold_long) out_ready <= 0;
		else out_ready <= ($urandom_range(0, 9) < 6) || ((idle_cycles / 64) % 2 == 1);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (out_valid && out_ready) hmac_sb.check_digest(digest_word, word_index, last_result);
	end

	always @(posedge clk) begin
		if (idle_cycles > 20000) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int sent;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// Directed: zero key, empty message, field extremes and short words.
		send_word(32'h0, 3'd0, 1, 0);
		send_word(32'hffffffff, 3'd4, 1, 0);
		send_word(32'h12345678, 3'd7, 0, 0);
		send_word(32'hdeadbeef, 3'd1, 0, 0);
		send_word(32'ha5a5a5a5, 3'd3, 0, 0);
		send_word(32'h5a5a5a5a, 3'd2, 0, 0);
		send_word(32'hcafef00d, 3'd5, 0, 0);
		send_word(32'h01020304, 3'd6, 1, 0);
		drain();
		load_key(1);
		for (int i = 0; i < 17; i++) send_word($urandom, 3'd4, i == 16, 0);
		drain();
		load_key(2);
		// Long receiver stall while more messages queue up.
		fork
			begin
				hold_long = 1;
				repeat (3000) @(posedge clk);
				hold_long = 0;
			end
			repeat (3) send_message($urandom_range(1, 3), 0);
		join
		drain();
		sent = 31;
		while (sent < 430) begin
			int n;
			if ($urandom_range(0, 4) == 0) begin
				drain();
				load_key($urandom_range(0, 2));
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 34) : $urandom_range(1, 6);
			send_message(n, 1);
			sent += n;
		end
		drain();
		if (hmac_sb.errors == 0 && hmac_sb.pending_digest.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// File: hmac_sha1_engine.f
sv/hse_pkg.sv
sv/hse_round.sv
sv/hmac_sha1_engine.sv
tb/sv/hmac_sha1_engine_tb.sv
